### hw/rtl/cleb_pkg.sv
// Package for the cursor line edit buffer.
// Holds sizes, request and status codes, controller states and the
// command and status structs between controller and datapath. No dependencies.
package cleb_pkg;

  // Store size and derived widths
  localparam int CAPACITY = 65536;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int POS_W    = 16;

  // Request codes
  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_LEFT   = 3'd1,
    REQ_RIGHT  = 3'd2,
    REQ_BACK   = 3'd3,
    REQ_READ   = 3'd4
  } req_type_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_EXEC   = 2'd1,
    S_MOVE   = 2'd2,
    S_FINISH = 2'd3
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic latch;    // capture the incoming word
    logic exec;     // first store access of the request
    logic move_wr;  // second access of a cursor move
    logic commit;   // update counts and load the result register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_move;  // accepted request is a cursor move that will happen
  } dp_sts_t;

endpackage

### hw/rtl/cleb_if.sv
// Handshake channels of the cursor line edit buffer: request and response.
// Depends on cleb_pkg for field widths.
interface cleb_req_if
  import cleb_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [2:0]       req_type;
  logic [7:0]       char_in;
  logic [POS_W-1:0] read_pos;

  modport source (output valid, output req_type, output char_in, output read_pos,
                  input ready);
  modport sink   (input valid, input req_type, input char_in, input read_pos,
                  output ready);
endinterface

interface cleb_rsp_if
  import cleb_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [7:0]       char_out;
  logic [CNT_W-1:0] text_length;
  logic [CNT_W-1:0] cursor_pos;
  logic [1:0]       status;

  modport source (output valid, output char_out, output text_length, output cursor_pos,
                  output status, input ready);
  modport sink   (input valid, input char_out, input text_length, input cursor_pos,
                  input status, output ready);
endinterface

### hw/rtl/cleb_ctrl.sv
// Controller of the cursor line edit buffer: sequences the store accesses
// of one request and owns the response valid flag. Depends on cleb_pkg.
module cleb_ctrl
  import cleb_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  output logic    req_ready_o,
  output logic    rsp_valid_o,
  input  logic    rsp_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || rsp_ready_i;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.is_move ? S_MOVE : S_FINISH;
      end
      S_MOVE: begin
        cmd_o.move_wr = 1'b1;
        state_d       = S_FINISH;
      end
      S_FINISH: begin
        // Hold until the result register is free
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result valid: set on commit, drop when taken
  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_valid_o = out_valid_q;

endmodule

### hw/rtl/cleb_dp.sv
// Datapath of the cursor line edit buffer: single-port text store, stack
// counts, request register and result register. Depends on cleb_pkg.
module cleb_dp
  import cleb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  output dp_sts_t          sts_o,
  input  logic [2:0]       req_type_i,
  input  logic [7:0]       char_in_i,
  input  logic [POS_W-1:0] read_pos_i,
  output logic [7:0]       char_out_o,
  output logic [CNT_W-1:0] text_length_o,
  output logic [CNT_W-1:0] cursor_pos_o,
  output logic [1:0]       status_o
);

  localparam logic [CNT_W-1:0] CapC = CNT_W'(CAPACITY);

  logic [7:0]       store_q [CAPACITY];
  logic [7:0]       rdata_q;
  logic [2:0]       req_q;
  logic [7:0]       ch_q;
  logic [POS_W-1:0] pos_q;
  logic [CNT_W-1:0] left_q, left_d, right_q, right_d, len;
  logic [CNT_W-1:0] pos_ext, rd_addr_ext;
  logic             op_ok, is_ins, is_read, is_fail_full;
  logic             mem_en, mem_we;
  logic [ADDR_W-1:0] addr;
  logic [7:0]       wdata;
  logic [7:0]       char_out_q;
  logic [CNT_W-1:0] len_out_q, cur_out_q;
  logic [1:0]       status_q;

  assign len     = left_q + right_q;
  assign pos_ext = CNT_W'(pos_q);
  assign rd_addr_ext = (pos_ext < left_q) ? pos_ext : (CapC - right_q + (pos_ext - left_q));
  assign is_ins  = (req_q == REQ_INSERT);
  assign is_read = (req_q == REQ_READ);
  assign is_fail_full = is_ins && !op_ok;

  // Decide whether the request takes effect and the next counts
  always_comb begin
    op_ok   = 1'b0;
    left_d  = left_q;
    right_d = right_q;
    unique case (req_q)
      REQ_INSERT: begin
        op_ok  = (len < CapC);
        left_d = left_q + CNT_W'(1);
      end
      REQ_LEFT: begin
        op_ok   = (left_q != '0);
        left_d  = left_q - CNT_W'(1);
        right_d = right_q + CNT_W'(1);
      end
      REQ_RIGHT: begin
        op_ok   = (right_q != '0);
        left_d  = left_q + CNT_W'(1);
        right_d = right_q - CNT_W'(1);
      end
      REQ_BACK: begin
        op_ok  = (left_q != '0);
        left_d = left_q - CNT_W'(1);
      end
      REQ_READ: op_ok = (pos_ext < len);
      default:  op_ok = 1'b0;
    endcase
    if (!op_ok) begin
      left_d  = left_q;
      right_d = right_q;
    end
  end

  assign sts_o.is_move = op_ok && ((req_q == REQ_LEFT) || (req_q == REQ_RIGHT));

  // Store port: address, data and enables
  always_comb begin
    mem_en = 1'b0;
    mem_we = 1'b0;
    addr   = left_q[ADDR_W-1:0];
    wdata  = ch_q;
    if (cmd_i.exec && op_ok) begin
      unique case (req_q)
        REQ_INSERT: begin
          mem_en = 1'b1;
          mem_we = 1'b1;
        end
        REQ_LEFT: begin
          mem_en = 1'b1;
          addr   = ADDR_W'(left_q - CNT_W'(1));
        end
        REQ_RIGHT: begin
          mem_en = 1'b1;
          addr   = ADDR_W'(CapC - right_q);
        end
        REQ_READ: begin
          mem_en = 1'b1;
          addr   = rd_addr_ext[ADDR_W-1:0];
        end
        default: mem_en = 1'b0;
      endcase
    end else if (cmd_i.move_wr) begin
      // Second half of a move: push the read byte on the other stack
      mem_en = 1'b1;
      mem_we = 1'b1;
      wdata  = rdata_q;
      addr   = (req_q == REQ_LEFT) ? ADDR_W'(CapC - CNT_W'(1) - right_q)
                                   : left_q[ADDR_W-1:0];
    end
  end

  // Text store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_en) begin
      if (mem_we) begin
        store_q[addr] <= wdata;
      end else begin
        rdata_q <= store_q[addr];
      end
    end
  end

  // Capture the request word
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_type_i;
      ch_q  <= char_in_i;
      pos_q <= read_pos_i;
    end
  end

  // Stack counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= '0;
    end else if (cmd_i.commit) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      char_out_q <= (is_read && op_ok) ? rdata_q : 8'd0;
      len_out_q  <= left_d + right_d;
      cur_out_q  <= left_d;
      if (op_ok) begin
        status_q <= ST_DONE;
      end else if (is_fail_full) begin
        status_q <= ST_FULL;
      end else begin
        status_q <= ST_IGNORED;
      end
    end
  end

  assign char_out_o    = char_out_q;
  assign text_length_o = len_out_q;
  assign cursor_pos_o  = cur_out_q;
  assign status_o      = status_q;

endmodule

### hw/rtl/cursor_line_edit_buffer.sv
// Top level of the cursor line edit buffer (gap buffer line editor).
// Depends on cleb_pkg, cleb_if, cleb_ctrl and cleb_dp.
//
// Usage:
//   req_i carries one request word: req_type (insert, cursor left, cursor
//   right, backspace, read at position), char_in and read_pos. rsp_o returns
//   one word per request: char_out, text_length, cursor_pos and status.
//   Text left of the cursor sits at the bottom of a 64K x 8 single-port
//   store, text right of it at the top.
// Timing:
//   A request steps through accept, execute (store access, if any) and
//   commit; cursor moves add a second store access, since they read one
//   stack top and write the other through the single store port. The next
//   request is taken in the cycle after the commit, not before.
// Reset:
//   Clears the counts (empty text, cursor at 0) and the response flag; the
//   store itself is not cleared and needs no clearing pass.
// Stall:
//   A result waits in the output register while the receiver stalls; a new
//   request may be accepted and runs up to its commit, then holds until
//   the output register is free.
module cursor_line_edit_buffer
  import cleb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  cleb_req_if.sink   req_i,
  cleb_rsp_if.source rsp_o
);

  dp_cmd_t cmd_s;
  dp_sts_t sts_s;

  cleb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts_s),
    .cmd_o       (cmd_s)
  );

  cleb_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_s),
    .sts_o         (sts_s),
    .req_type_i    (req_i.req_type),
    .char_in_i     (req_i.char_in),
    .read_pos_i    (req_i.read_pos),
    .char_out_o    (rsp_o.char_out),
    .text_length_o (rsp_o.text_length),
    .cursor_pos_o  (rsp_o.cursor_pos),
    .status_o      (rsp_o.status)
  );

  // Cursor never passes the end of the text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.cursor_pos <= rsp_o.text_length))
    else $error("cursor beyond text length");

  // Text never exceeds the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.text_length <= CNT_W'(CAPACITY)))
    else $error("text length beyond capacity");

  // A commit always presents a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_s.commit |=> rsp_o.valid)
    else $error("commit without result");

  // One request at a time: busy after accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while busy");

endmodule
